// ----- design/ncs_pkg.sv -----
// Shared types, widths and codes of the nearest codeword search block.
// No dependencies; every other file in this folder but ncs_ram imports it.
`default_nettype none

package ncs_pkg;

	localparam int MAX_CODEWORDS = 256;
	localparam int MAX_DIMS      = 16;
	localparam int PIXEL_BITS    = 8;

	// fixed field widths of the stream words
	localparam int TYPE_W  = 1;
	localparam int ENTRY_W = 8;
	localparam int ELEM_W  = 4;
	localparam int VALUE_W = 8;
	localparam int NIDX_W  = 8;
	localparam int DIST_W  = 20;

	localparam int IN_DATA_W  = ((ENTRY_W + ELEM_W + VALUE_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((NIDX_W + DIST_W + 7) / 8) * 8;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 9;
	localparam int KREG_W     = 9;
	localparam int DREG_W     = 5;
	localparam logic [CFG_IDX_W-1:0] REG_CODEWORDS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_DIMS      = 1'b1;
	localparam logic [KREG_W-1:0] KREG_RESET = 9'd256;
	localparam logic [DREG_W-1:0] DREG_RESET = 5'd16;

	localparam logic [TYPE_W-1:0] REQ_LOAD  = 1'b0;
	localparam logic [TYPE_W-1:0] REQ_POINT = 1'b1;

	// derived storage widths
	localparam int PIX_W     = PIXEL_BITS;
	localparam int SQ_W      = 2 * PIXEL_BITS;
	localparam int CW_IDX_W  = $clog2(MAX_CODEWORDS);
	localparam int DIM_IDX_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int CB_DEPTH  = MAX_CODEWORDS * MAX_DIMS;
	localparam int CB_ADDR_W = $clog2(CB_DEPTH);

	localparam longint unsigned PIX_MAX  = (64'd1 << PIXEL_BITS) - 64'd1;
	localparam longint unsigned DIST_MAX = PIX_MAX * PIX_MAX * MAX_DIMS;
	localparam int SUM_W = $clog2(DIST_MAX + 64'd1);
	localparam int ACC_W = (SUM_W > DIST_W) ? SUM_W : DIST_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH,
		ST_FINISH
	} state_t;

	// one codebook/point read issued by the sequencer
	typedef struct packed {
		logic                valid;
		logic                last_elem;
		logic                last_code;
		logic [CW_IDX_W-1:0] code;
	} issue_t;

endpackage

`default_nettype wire

// ----- design/nearest_codeword_search.sv -----
// Nearest codeword search: a load word (tuser 0) writes one pixel of one codeword
// into the codebook memory. A point word (tuser 1) stores one pixel of the input
// vector; the pixel at position dims_in_use-1 starts a search over codewords
// 0..K-1 by sum of squared differences, first codeword winning ties. After a
// completing point word the search scans K codewords of D pixels each before its
// result is registered; the single read port of the codebook memory reads one
// pixel per cycle of the scan. s_tready stays low during a search.
// Depends on ncs_pkg, ncs_ram, ncs_ctrl and ncs_dist.
`default_nettype none

module nearest_codeword_search (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [ncs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [ncs_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// entry_index [7:0], element_index [11:8], element_value [19:12], zero [23:20]
	input  wire logic [ncs_pkg::IN_DATA_W-1:0]      s_tdata,
	// req_type [0]
	input  wire logic [ncs_pkg::TYPE_W-1:0]         s_tuser,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// nearest_index [7:0], nearest_distance_sq [27:8], zero [31:28]
	output logic      [ncs_pkg::OUT_DATA_W-1:0]     m_tdata
);

	import ncs_pkg::*;

	logic [KREG_W-1:0]     codewords_q;
	logic [DREG_W-1:0]     dims_q;
	logic [CW_IDX_W-1:0]   klast;
	logic [DIM_IDX_W-1:0]  dlast;

	logic [ENTRY_W-1:0]    entry_index;
	logic [ELEM_W-1:0]     element_index;
	logic [VALUE_W-1:0]    element_value;
	logic [PIX_W-1:0]      pixel;
	logic                  accept, load_hit, point_hit, start;
	logic [CB_ADDR_W-1:0]  cb_waddr;

	logic                  busy, load_out, done, out_free;
	issue_t                issue;
	logic [CB_ADDR_W-1:0]  cb_raddr;
	logic [DIM_IDX_W-1:0]  pt_raddr;
	logic [PIX_W-1:0]      cb_rdata, pt_rdata;
	logic [CW_IDX_W-1:0]   best_k;
	logic [ACC_W-1:0]      best_d;

	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codewords_q <= KREG_RESET;
			dims_q      <= DREG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CODEWORDS: codewords_q <= KREG_W'(cfg_data);
				REG_DIMS:      dims_q      <= DREG_W'(cfg_data);
				default:       ;
			endcase
		end
	end

	// saturate the counts into [1, max] and keep the last index
	always_comb begin
		int k_eff;
		int d_eff;
		k_eff = int'(codewords_q);
		d_eff = int'(dims_q);
		if (k_eff == 0) k_eff = 1;
		if (k_eff > MAX_CODEWORDS) k_eff = MAX_CODEWORDS;
		if (d_eff == 0) d_eff = 1;
		if (d_eff > MAX_DIMS) d_eff = MAX_DIMS;
		klast = CW_IDX_W'(k_eff - 1);
		dlast = DIM_IDX_W'(d_eff - 1);
	end

	assign entry_index   = s_tdata[ENTRY_W-1:0];
	assign element_index = s_tdata[ENTRY_W+ELEM_W-1:ENTRY_W];
	assign element_value = s_tdata[ENTRY_W+ELEM_W+VALUE_W-1:ENTRY_W+ELEM_W];
	assign pixel         = PIX_W'(element_value);

	assign s_tready  = !busy;
	assign accept    = s_tvalid && s_tready;
	assign load_hit  = accept && (s_tuser == REQ_LOAD) && (int'(entry_index) < MAX_CODEWORDS)
	                   && (int'(element_index) < MAX_DIMS);
	assign point_hit = accept && (s_tuser == REQ_POINT) && (int'(element_index) < MAX_DIMS);
	assign start     = point_hit && (DIM_IDX_W'(element_index) == dlast);
	assign cb_waddr  = CB_ADDR_W'(int'(entry_index) * MAX_DIMS + int'(element_index));

	ncs_ram #(
		.WIDTH (PIX_W),
		.DEPTH (CB_DEPTH)
	) u_codebook (
		.clk     (clk),
		.we      (load_hit),
		.waddr   (cb_waddr),
		.wdata   (pixel),
		.raddr   (cb_raddr),
		.rdata_q (cb_rdata)
	);

	ncs_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_DIMS)
	) u_point (
		.clk     (clk),
		.we      (point_hit),
		.waddr   (DIM_IDX_W'(element_index)),
		.wdata   (pixel),
		.raddr   (pt_raddr),
		.rdata_q (pt_rdata)
	);

	ncs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.done     (done),
		.out_free (out_free),
		.klast    (klast),
		.dlast    (dlast),
		.busy     (busy),
		.load_out (load_out),
		.issue    (issue),
		.cb_raddr (cb_raddr),
		.pt_raddr (pt_raddr)
	);

	ncs_dist u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.issue    (issue),
		.cb_rdata (cb_rdata),
		.pt_rdata (pt_rdata),
		.best_k_q (best_k),
		.best_d_q (best_d),
		.done_q   (done)
	);

	// output word register
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tdata_q <= OUT_DATA_W'({best_d[DIST_W-1:0], NIDX_W'(best_k)});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// a finished search never lands outside a search
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("search finished while sequencer idle");

	// a new result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!m_tvalid || m_tready))
		else $error("result register overwritten");

	// reads are issued only while input is held off
	a_issue_stall: assert property (@(posedge clk) disable iff (!arst_n)
		issue.valid |-> !s_tready)
		else $error("codebook read issued while accepting input");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> m_tvalid)
		else $error("loaded result not presented");

endmodule

`default_nettype wire

// ----- design/ncs_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module ncs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                        clk,
	input  wire logic                                        we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                            wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                            rdata_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- design/ncs_ctrl.sv -----
// Search sequencer: walks codeword and element counters over the codebook memory.
// Depends on ncs_pkg.
`default_nettype none

module ncs_ctrl (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	input  wire logic                             done,
	input  wire logic                             out_free,
	input  wire logic [ncs_pkg::CW_IDX_W-1:0]     klast,
	input  wire logic [ncs_pkg::DIM_IDX_W-1:0]    dlast,
	output logic                                  busy,
	output logic                                  load_out,
	output ncs_pkg::issue_t                       issue,
	output logic      [ncs_pkg::CB_ADDR_W-1:0]    cb_raddr,
	output logic      [ncs_pkg::DIM_IDX_W-1:0]    pt_raddr
);

	import ncs_pkg::*;

	state_t                state_q, state_d;
	logic [CW_IDX_W-1:0]   k_q;
	logic [DIM_IDX_W-1:0]  i_q;
	logic [CB_ADDR_W-1:0]  base_q;
	logic                  elem_end, code_end;

	assign elem_end = (i_q == dlast);
	assign code_end = (k_q == klast);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (start) state_d = ST_SCAN;
			ST_SCAN:   if (elem_end && code_end) state_d = ST_FLUSH;
			ST_FLUSH:  if (done) state_d = ST_FINISH;
			ST_FINISH: if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy            = (state_q != ST_IDLE);
		load_out        = (state_q == ST_FINISH) && out_free;
		issue.valid     = (state_q == ST_SCAN);
		issue.last_elem = elem_end;
		issue.last_code = code_end;
		issue.code      = k_q;
		cb_raddr        = base_q + CB_ADDR_W'(i_q);
		pt_raddr        = i_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			i_q     <= '0;
			base_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) begin
				k_q    <= '0;
				i_q    <= '0;
				base_q <= '0;
			end else if (state_q == ST_SCAN) begin
				// advance to the next codeword row at the end of a vector
				if (elem_end) begin
					i_q    <= '0;
					k_q    <= CW_IDX_W'(k_q + 1'b1);
					base_q <= CB_ADDR_W'(base_q + CB_ADDR_W'(MAX_DIMS));
				end else begin
					i_q <= DIM_IDX_W'(i_q + 1'b1);
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- design/ncs_dist.sv -----
// Distance datapath: absolute difference and square, then accumulate and keep the best.
// Depends on ncs_pkg.
`default_nettype none

module ncs_dist (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire ncs_pkg::issue_t               issue,
	input  wire logic [ncs_pkg::PIX_W-1:0]     cb_rdata,
	input  wire logic [ncs_pkg::PIX_W-1:0]     pt_rdata,
	output logic      [ncs_pkg::CW_IDX_W-1:0]  best_k_q,
	output logic      [ncs_pkg::ACC_W-1:0]     best_d_q,
	output logic                               done_q
);

	import ncs_pkg::*;

	issue_t            issue_s1, issue_s2;
	logic [PIX_W-1:0]  diff;
	logic [SQ_W-1:0]   sq_s2;
	logic [ACC_W-1:0]  acc_q;
	logic [ACC_W-1:0]  sum;
	logic              take;

	assign diff = (pt_rdata >= cb_rdata) ? PIX_W'(pt_rdata - cb_rdata)
	                                     : PIX_W'(cb_rdata - pt_rdata);
	assign sum  = ACC_W'(acc_q + ACC_W'(sq_s2));
	// strict compare keeps the earliest codeword on ties
	assign take = (issue_s2.code == '0) || (sum < best_d_q);

	always_ff @(posedge clk) begin
		sq_s2 <= SQ_W'(diff * diff);
		if (issue_s2.valid && issue_s2.last_elem && take) begin
			best_k_q <= issue_s2.code;
			best_d_q <= sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_s1 <= '0;
			issue_s2 <= '0;
			acc_q    <= '0;
			done_q   <= 1'b0;
		end else begin
			issue_s1 <= issue;
			issue_s2 <= issue_s1;
			done_q   <= issue_s2.valid && issue_s2.last_elem && issue_s2.last_code;
			if (issue_s2.valid) begin
				acc_q <= issue_s2.last_elem ? '0 : sum;
			end
		end
	end

endmodule

`default_nettype wire

// ----- bench/ncs_checker.sv -----
`timescale 1ns / 1ps
// Checker for nearest_codeword_search: follows the register port and both streams, keeps its
// own codebook, point pixels and register copies, and checks each result word. Uses ncs_pkg.
module ncs_checker
	import ncs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic [TYPE_W-1:0]     s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,
	output int                    fails,
	output int                    pending,
	output int                    searches
);

	typedef struct packed {
		logic [NIDX_W-1:0] index;
		logic [DIST_W-1:0] dsq;
	} match_t;

	logic [PIX_W-1:0]  codebook [MAX_CODEWORDS][MAX_DIMS];
	logic [PIX_W-1:0]  point_pix [MAX_DIMS];
	logic [KREG_W-1:0] kreg;
	logic [DREG_W-1:0] dreg;
	match_t            nearest_q [$];

	function automatic int unsigned dims_eff();
		if (dreg == 0) return 1;
		if (dreg > MAX_DIMS) return MAX_DIMS;
		return 32'(dreg);
	endfunction

	// full scan over the codewords in use; strict less-than keeps the earliest on ties
	function automatic match_t nearest_codeword();
		int unsigned kn, dn, sum, diff;
		match_t best;
		kn = (kreg == 0) ? 1 : ((kreg > MAX_CODEWORDS) ? MAX_CODEWORDS : 32'(kreg));
		dn = dims_eff();
		best = '0;
		for (int unsigned k = 0; k < kn; k++) begin
			sum = 0;
			for (int unsigned i = 0; i < dn; i++) begin
				diff = (point_pix[i] >= codebook[k][i])
					? 32'(point_pix[i]) - 32'(codebook[k][i])
					: 32'(codebook[k][i]) - 32'(point_pix[i]);
				sum += diff * diff;
			end
			if (k == 0 || sum < best.dsq) begin
				best.dsq   = sum[DIST_W-1:0];
				best.index = k[NIDX_W-1:0];
			end
		end
		return best;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		logic [ENTRY_W-1:0] entry;
		logic [ELEM_W-1:0]  elem;
		logic [VALUE_W-1:0] value;
		match_t             got, want;
		if (!arst_n) begin
			kreg = KREG_RESET;
			dreg = DREG_RESET;
			nearest_q.delete();
			fails = 0;
			pending = 0;
			searches = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_CODEWORDS) kreg = cfg_data[KREG_W-1:0];
				else if (cfg_index == REG_DIMS) dreg = cfg_data[DREG_W-1:0];
			end
			if (s_tvalid && s_tready) begin
				entry = s_tdata[ENTRY_W-1:0];
				elem  = s_tdata[ENTRY_W +: ELEM_W];
				value = s_tdata[ENTRY_W+ELEM_W +: VALUE_W];
				if (s_tuser == REQ_LOAD) begin
					codebook[entry][elem] = value;
				end else begin
					point_pix[elem] = value;
					if (32'(elem) == dims_eff() - 1) nearest_q.push_back(nearest_codeword());
				end
			end
			if (m_tvalid && m_tready) begin
				got.index = m_tdata[NIDX_W-1:0];
				got.dsq   = m_tdata[NIDX_W +: DIST_W];
				if (nearest_q.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("%0t: unexpected result word, index %0d distance %0d",
							$time, got.index, got.dsq);
				end else begin
					want = nearest_q.pop_front();
					searches++;
					if (got.index != want.index || got.dsq != want.dsq) begin
						fails++;
						if (fails <= 10)
							$display({"%0t: search %0d expected index %0d distance %0d,",
								" got index %0d distance %0d"},
								$time, searches, want.index, want.dsq,
								got.index, got.dsq);
					end
				end
			end
			pending = nearest_q.size();
		end
	end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Bench top for nearest_codeword_search: clock, reset, register writes, load and point words
// with random gaps, and output stalls. Uses ncs_pkg, ncs_checker and the design files.
module tb_top;
	import ncs_pkg::*;

	localparam int RANDOM_WORDS = 450;
	localparam int RX_HOLD      = 300;
	localparam int IDLE_LIMIT   = 20000;
	localparam int TAIL_CYCLES  = 300;
	localparam int VAL_FULL     = 0;
	localparam int VAL_NARROW   = 1;
	localparam int VAL_EXTREME  = 2;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [TYPE_W-1:0]     s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	int                    fails, pending, searches;

	// which codebook cells hold a written value
	logic [MAX_DIMS-1:0] cb_written [MAX_CODEWORDS];
	int                  k_eff, d_eff;
	bit                  quiet;
	int                  holds_asked;
	int                  words_sent, settings;
	int                  idle_cycles;

	always #2 clk = ~clk;

	nearest_codeword_search dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	ncs_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.fails(fails), .pending(pending), .searches(searches)
	);

	function automatic logic [VALUE_W-1:0] pick_value(input int mode);
		case (mode)
			VAL_NARROW:  return VALUE_W'($urandom_range(0, 3));
			VAL_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
			default:     return VALUE_W'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic put_word(input logic [TYPE_W-1:0] req, input logic [ENTRY_W-1:0] entry,
			input logic [ELEM_W-1:0] elem, input logic [VALUE_W-1:0] value);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 16);
		if (gap != 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = req;
		s_tdata  = '0;
		s_tdata[ENTRY_W-1:0] = entry;
		s_tdata[ENTRY_W +: ELEM_W] = elem;
		s_tdata[ENTRY_W+ELEM_W +: VALUE_W] = value;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		if (req == REQ_LOAD) cb_written[entry][elem] = 1'b1;
		words_sent++;
	endtask

	// hold the input until every search has reported, then let loads settle
	task automatic settle_idle();
		s_tvalid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_regs(input int kraw, input int draw);
		settle_idle();
		cfg_we    = 1'b1;
		cfg_index = REG_CODEWORDS;
		cfg_data  = CFG_DATA_W'(kraw);
		@(negedge clk);
		cfg_index = REG_DIMS;
		cfg_data  = CFG_DATA_W'(draw);
		@(negedge clk);
		cfg_we = 1'b0;
		k_eff = (kraw == 0) ? 1 : ((kraw > MAX_CODEWORDS) ? MAX_CODEWORDS : kraw);
		d_eff = (draw == 0) ? 1 : ((draw > MAX_DIMS) ? MAX_DIMS : draw);
		settings++;
	endtask

	// write every cell a search can read that has not been written yet
	task automatic fill_codebook(input int mode);
		for (int k = 0; k < k_eff; k++)
			for (int i = 0; i < d_eff; i++)
				if (!cb_written[k][i])
					put_word(REQ_LOAD, ENTRY_W'(k), ELEM_W'(i), pick_value(mode));
	endtask

	// point pixels 0..count-1; count == d_eff completes a vector
	task automatic send_pixels(input int mode, input int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 7) == 0)
				put_word(REQ_LOAD, ENTRY_W'($urandom_range(0, k_eff - 1)),
					ELEM_W'($urandom_range(0, d_eff - 1)), pick_value(mode));
			put_word(REQ_POINT, ENTRY_W'($urandom_range(0, 255)), ELEM_W'(i),
				pick_value(mode));
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles, %0d results outstanding",
				IDLE_LIMIT, pending);
			$display("status: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : receiver
		int holds_done, stall;
		holds_done = 0;
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (holds_done != holds_asked) begin
				m_tready = 1'b0;
				repeat (RX_HOLD) @(negedge clk);
				holds_done++;
			end
			stall = quiet ? 0 : $urandom_range(0, 16);
			if (stall != 0) begin
				m_tready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready = 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	initial begin : stimulus
		int p, kind, mode, r, first;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = REQ_LOAD;
		quiet     = 1'b0;
		holds_asked = 0;
		words_sent  = 0;
		settings    = 0;
		for (int k = 0; k < MAX_CODEWORDS; k++) cb_written[k] = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// zero counts saturate up to one codeword of one pixel
		set_regs(0, 0);
		put_word(REQ_LOAD, 0, 0, 8'hFF);
		put_word(REQ_POINT, 8'hFF, 0, 8'h00);
		put_word(REQ_POINT, 0, 3, 8'h5A);
		set_regs(3, 2);
		put_word(REQ_LOAD, 0, 1, 200);
		put_word(REQ_LOAD, 1, 0, 7);
		put_word(REQ_LOAD, 1, 1, 9);
		put_word(REQ_LOAD, 2, 0, 7);
		put_word(REQ_LOAD, 2, 1, 9);
		// lane 0 still holds the earlier pixel; codewords 1 and 2 tie
		put_word(REQ_POINT, 0, 1, 9);
		put_word(REQ_POINT, 0, 0, 7);
		put_word(REQ_POINT, 0, 1, 9);
		put_word(REQ_LOAD, 8'hFF, 4'hF, 8'hFF);
		put_word(REQ_POINT, 0, 4'hF, 8'hFF);

		p = 0;
		first = words_sent;
		while (words_sent - first < RANDOM_WORDS) begin
			case (p)
				0: set_regs(MAX_CODEWORDS, 1);
				1: set_regs(2, 2);
				2: set_regs(0, 31);
				3: set_regs(511, 0);
				default: begin
					kind = $urandom_range(0, 9);
					if (kind == 0)
						set_regs($urandom_range(0, 1) ? 0 : $urandom_range(256, 511),
							$urandom_range(0, 1));
					else if (kind == 1)
						set_regs($urandom_range(1, 4),
							$urandom_range(0, 1) ? MAX_DIMS : $urandom_range(17, 31));
					else
						set_regs($urandom_range(1, 16), $urandom_range(1, 6));
				end
			endcase
			mode  = $urandom_range(VAL_FULL, VAL_EXTREME);
			quiet = ($urandom_range(0, 3) == 0);
			fill_codebook(mode);
			if (p == 2) begin
				// full-scale distance, then an exact match on a zero codeword
				for (int i = 0; i < MAX_DIMS; i++) put_word(REQ_LOAD, 0, ELEM_W'(i), 8'h00);
				for (int i = 0; i < MAX_DIMS; i++) put_word(REQ_POINT, 0, ELEM_W'(i), 8'hFF);
				for (int i = 0; i < MAX_DIMS; i++)
					put_word(REQ_POINT, 8'hFF, ELEM_W'(i), 8'h00);
			end
			if (p == 1) begin
				// stall the output while vectors keep coming, so the input backs up
				quiet = 1'b1;
				holds_asked++;
				repeat (12) send_pixels(mode, d_eff);
			end
			// every point lane in range is written by now, so any pixel may complete a vector
			repeat ($urandom_range(6, 14)) begin
				r = $urandom_range(0, 9);
				if (r < 7)
					send_pixels(mode, d_eff);
				else if (r == 7)
					put_word(REQ_LOAD, ENTRY_W'($urandom_range(0, 255)),
						ELEM_W'($urandom_range(0, 15)), pick_value(mode));
				else if (r == 8)
					put_word(REQ_POINT, ENTRY_W'($urandom_range(0, 255)),
						ELEM_W'($urandom_range(0, 15)), pick_value(mode));
				else
					send_pixels(mode, $urandom_range(0, d_eff - 1));
			end
			p++;
		end

		settle_idle();
		repeat (TAIL_CYCLES) @(negedge clk);
		$display("covered %0d stream words over %0d register settings, %0d searches checked",
			words_sent, settings, searches);
		$display("saturated counts, ties, stale and out-of-vector pixels,");
		$display("full-scale distance, output stall with input backed up");
		if (fails == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end

endmodule

// ----- filelist.f -----
design/ncs_pkg.sv
design/ncs_ram.sv
design/ncs_ctrl.sv
design/ncs_dist.sv
design/nearest_codeword_search.sv
bench/ncs_checker.sv
bench/tb_top.sv
